@@ src/ccirc_pkg.sv @@
// Shared widths, constants and payload types of the circumcircle circumference block.
package ccirc_pkg;

	localparam int COORD_BITS = 40;
	localparam int OUT_BITS   = 48;

	localparam int LIMB_W  = 32;
	localparam int MUL_LAT = 5;

	localparam int DIF_W = COORD_BITS + 1;
	localparam int SUM_W = COORD_BITS + 2;
	localparam int P1_W  = 2 * DIF_W;
	localparam int DET_W = P1_W + 1;
	localparam int P2_W  = SUM_W + DET_W;
	localparam int U_W   = P2_W + 1;
	localparam int NUM_W = U_W + 1;
	localparam int DEN_W = DET_W + 1;

	localparam int Q_W       = OUT_BITS - 2;
	localparam int SQI_W     = Q_W + 1;
	localparam int SQP_W     = 2 * SQI_W;
	localparam int T_W       = 2 * Q_W + 1;
	localparam int RAD_SHIFT = 32;
	localparam int RAD_W     = T_W + RAD_SHIFT;
	localparam int ROOT_W    = (RAD_W + 1) / 2;

	localparam int TWOPI_W = 51;
	localparam logic [TWOPI_W-1:0] TWOPI_Q48 = 51'h6487ED5110B46;
	localparam int FIN_W     = TWOPI_W + 1 + ROOT_W + 1;
	localparam int ROUND_POS = 64;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] first_x;
		logic signed [COORD_BITS-1:0] first_y;
		logic signed [COORD_BITS-1:0] second_x;
		logic signed [COORD_BITS-1:0] second_y;
		logic signed [COORD_BITS-1:0] third_x;
		logic signed [COORD_BITS-1:0] third_y;
	} ccirc_pts_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] circumference;
		logic                collinear_flag;
		logic                saturated_flag;
	} ccirc_res_t;

endpackage

@@ src/ccirc_mul.sv @@
// Pipelined signed multiplier built from 32 by 32 bit partial products.
module ccirc_mul #(
	parameter int AW = 41,
	parameter int BW = 41
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	output logic signed [AW+BW-1:0] p
);
	import ccirc_pkg::*;

	localparam int NA  = (AW + LIMB_W - 1) / LIMB_W;
	localparam int NB  = (BW + LIMB_W - 1) / LIMB_W;
	localparam int PW  = AW + BW;
	localparam int AP  = NA * LIMB_W;
	localparam int BP  = NB * LIMB_W;
	localparam int RW  = BP + LIMB_W;
	localparam int SW  = AP + BP;
	localparam int PPW = 2 * LIMB_W;

	logic [AW-1:0]  abs_a;
	logic [BW-1:0]  abs_b;
	logic [AP-1:0]  ma_s1;
	logic [BP-1:0]  mb_s1;
	logic           neg_s1, neg_s2, neg_s3, neg_s4;
	logic [PPW-1:0] pp_s2 [NA][NB];
	logic [RW-1:0]  ev_c [NA];
	logic [RW-1:0]  od_c [NA];
	logic [RW-1:0]  row_c [NA];
	logic [RW-1:0]  row_s3 [NA];
	logic [SW-1:0]  sum_c;
	logic [SW-1:0]  sum_s4;

	assign abs_a = a[AW-1] ? AW'(-a) : AW'(a);
	assign abs_b = b[BW-1] ? BW'(-b) : BW'(b);

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			ev_c[i] = '0;
			od_c[i] = '0;
			for (int j = 0; j < NB; j++) begin
				if (j % 2 == 0) begin
					ev_c[i] = ev_c[i] | (RW'(pp_s2[i][j]) << (j * LIMB_W));
				end else begin
					od_c[i] = od_c[i] | (RW'(pp_s2[i][j]) << (j * LIMB_W));
				end
			end
			row_c[i] = ev_c[i] + od_c[i];
		end
	end

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < NA; i++) begin
			sum_c = sum_c + (SW'(row_s3[i]) << (i * LIMB_W));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1  <= AP'(abs_a);
			mb_s1  <= BP'(abs_b);
			neg_s1 <= a[AW-1] ^ b[BW-1];
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s2[i][j] <= PPW'(ma_s1[i*LIMB_W +: LIMB_W]) *
						PPW'(mb_s1[j*LIMB_W +: LIMB_W]);
				end
			end
			neg_s2 <= neg_s1;
			row_s3 <= row_c;
			neg_s3 <= neg_s2;
			sum_s4 <= sum_c;
			neg_s4 <= neg_s3;
			p      <= neg_s4 ? -PW'(sum_s4) : PW'(sum_s4);
		end
	end

endmodule

@@ src/ccirc_div.sv @@
// Pipelined restoring divider with one quotient bit per stage and an overflow flag.
module ccirc_div #(
	parameter int NW = 127,
	parameter int DW = 84,
	parameter int QW = 46
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] n,
	input  logic [DW-1:0] d,
	output logic [QW-1:0] q,
	output logic          ovf
);
	import ccirc_pkg::*;

	localparam int RW = (NW > DW + QW) ? NW : DW + QW;

	logic [RW-1:0] rem_s [QW+1];
	logic [DW-1:0] den_s [QW+1];
	logic [QW-1:0] quo_s [QW+1];
	logic          ovf_s [QW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= RW'(n);
			den_s[0] <= d;
			quo_s[0] <= '0;
			ovf_s[0] <= RW'(n) >= (RW'(d) << QW);
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		localparam int B = QW - 1 - k;
		logic [RW:0] dif;

		assign dif = {1'b0, rem_s[k]} - {1'b0, RW'(den_s[k]) << B};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= dif[RW] ? rem_s[k] : dif[RW-1:0];
				quo_s[k+1] <= quo_s[k] | (QW'(!dif[RW]) << B);
				den_s[k+1] <= den_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	assign q   = quo_s[QW];
	assign ovf = ovf_s[QW];

endmodule

@@ src/circumcircle_circumference_top.sv @@
// Top level of the circumcircle circumference pipeline.
// Takes three points per transfer and returns 2*pi times the radius of the circle through
// them, in the input's fixed-point scale. The pipeline accepts one transfer every cycle and
// passes each through the two determinant multiplier rows, the 46-stage divider, the
// squaring multipliers, the 63-stage square root and the final constant multiplier. When a
// result waits at the output, the whole pipeline holds and no new transfer is taken.
// Collinear points give zero with the collinear flag; results beyond the output range
// saturate with the saturated flag.
module circumcircle_circumference_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pts_valid,
	output logic                   pts_ready,
	input  ccirc_pkg::ccirc_pts_t  pts,
	output logic                   res_valid,
	input  logic                   res_ready,
	output ccirc_pkg::ccirc_res_t  res
);
	import ccirc_pkg::*;

	localparam int ST_DET   = 1 + MUL_LAT + 1;
	localparam int ST_U     = ST_DET + MUL_LAT + 1;
	localparam int ST_ABS   = ST_U + 1;
	localparam int ST_NUM   = ST_ABS + 1;
	localparam int ST_Q     = ST_NUM + Q_W + 1;
	localparam int ST_T     = ST_Q + MUL_LAT + 1;
	localparam int ST_ROOT  = ST_T + ROOT_W;
	localparam int ST_OUT   = ST_ROOT + MUL_LAT + 1;
	localparam int GEO_DLY  = ST_DET - 1;
	localparam int D2_DLY   = ST_U - ST_DET;
	localparam int COLL_DLY = ST_OUT - 1 - ST_DET;
	localparam int SAT_DLY  = ST_OUT - 1 - ST_Q;
	localparam int TR_W     = RAD_W + 2;

	typedef struct packed {
		logic signed [SUM_W-1:0] sx;
		logic signed [SUM_W-1:0] sy;
		logic signed [DIF_W-1:0] y21;
		logic signed [DIF_W-1:0] x12;
	} geo_t;

	logic                en;
	logic [ST_OUT:1]     vld_s;

	logic signed [DIF_W-1:0] ay_s1, y20_s1, x20_s1, cx_s1, x21_s1, y12_s1;
	geo_t                    geo_s1;
	geo_t                    geo_dl [GEO_DLY];

	logic signed [P1_W-1:0]  p1, p2, p3, p4;
	logic signed [DET_W-1:0] d1x2_s7, d2_s7;
	logic                    coll_s7;
	logic signed [DET_W-1:0] d2_dl [D2_DLY];
	logic                    coll_dl [COLL_DLY];

	logic signed [P2_W-1:0]  m1, m2, m3, m4;
	logic signed [U_W-1:0]   ux_s13, uy_s13;
	logic [U_W-1:0]          uxa_s14, uya_s14;
	logic [DET_W-1:0]        ad_s14;
	logic [NUM_W-1:0]        numx_s15, numy_s15;
	logic [DEN_W-1:0]        den_s15;

	logic [Q_W-1:0]          qx, qy;
	logic                    ovfx, ovfy;
	logic                    sat_dl [SAT_DLY];

	logic signed [SQP_W-1:0] sqx, sqy;
	logic [T_W-1:0]          t_s68;
	logic [RAD_W-1:0]        rt_rem_s [ROOT_W];
	logic [ROOT_W-1:0]       rt_root_s [ROOT_W];

	logic signed [FIN_W-1:0] prod;
	logic [FIN_W-1:0]        p_c;
	logic                    sat2_c;
	ccirc_res_t              res_s137;

	assign en        = !vld_s[ST_OUT] || res_ready;
	assign pts_ready = en;
	assign res_valid = vld_s[ST_OUT];
	assign res       = res_s137;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[ST_OUT-1:1], pts_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ay_s1      <= DIF_W'(pts.second_y) - DIF_W'(pts.first_y);
			y20_s1     <= DIF_W'(pts.third_y) - DIF_W'(pts.first_y);
			x20_s1     <= DIF_W'(pts.third_x) - DIF_W'(pts.first_x);
			cx_s1      <= DIF_W'(pts.first_x) - DIF_W'(pts.second_x);
			x21_s1     <= DIF_W'(pts.third_x) - DIF_W'(pts.second_x);
			y12_s1     <= DIF_W'(pts.second_y) - DIF_W'(pts.third_y);
			geo_s1.sx  <= SUM_W'(pts.second_x) + SUM_W'(pts.third_x) -
				(SUM_W'(pts.first_x) <<< 1);
			geo_s1.sy  <= SUM_W'(pts.second_y) + SUM_W'(pts.third_y) -
				(SUM_W'(pts.first_y) <<< 1);
			geo_s1.y21 <= DIF_W'(pts.third_y) - DIF_W'(pts.second_y);
			geo_s1.x12 <= DIF_W'(pts.second_x) - DIF_W'(pts.third_x);
			geo_dl[0]  <= geo_s1;
			for (int k = 1; k < GEO_DLY; k++) begin
				geo_dl[k] <= geo_dl[k-1];
			end
		end
	end

	ccirc_mul #(.AW(DIF_W), .BW(DIF_W)) u_mul_p1 (
		.clk(clk), .en(en), .a(ay_s1), .b(y20_s1), .p(p1));
	ccirc_mul #(.AW(DIF_W), .BW(DIF_W)) u_mul_p2 (
		.clk(clk), .en(en), .a(x20_s1), .b(cx_s1), .p(p2));
	ccirc_mul #(.AW(DIF_W), .BW(DIF_W)) u_mul_p3 (
		.clk(clk), .en(en), .a(ay_s1), .b(x21_s1), .p(p3));
	ccirc_mul #(.AW(DIF_W), .BW(DIF_W)) u_mul_p4 (
		.clk(clk), .en(en), .a(y12_s1), .b(cx_s1), .p(p4));

	always_ff @(posedge clk) begin
		if (en) begin
			d1x2_s7  <= DET_W'(p1) - DET_W'(p2);
			d2_s7    <= DET_W'(p3) - DET_W'(p4);
			coll_s7  <= p3 == p4;
			d2_dl[0] <= d2_s7;
			for (int k = 1; k < D2_DLY; k++) begin
				d2_dl[k] <= d2_dl[k-1];
			end
			coll_dl[0] <= coll_s7;
			for (int k = 1; k < COLL_DLY; k++) begin
				coll_dl[k] <= coll_dl[k-1];
			end
		end
	end

	ccirc_mul #(.AW(SUM_W), .BW(DET_W)) u_mul_m1 (
		.clk(clk), .en(en), .a(geo_dl[GEO_DLY-1].sx), .b(d2_s7), .p(m1));
	ccirc_mul #(.AW(SUM_W), .BW(DET_W)) u_mul_m2 (
		.clk(clk), .en(en), .a(SUM_W'(geo_dl[GEO_DLY-1].y21)), .b(d1x2_s7), .p(m2));
	ccirc_mul #(.AW(SUM_W), .BW(DET_W)) u_mul_m3 (
		.clk(clk), .en(en), .a(geo_dl[GEO_DLY-1].sy), .b(d2_s7), .p(m3));
	ccirc_mul #(.AW(SUM_W), .BW(DET_W)) u_mul_m4 (
		.clk(clk), .en(en), .a(SUM_W'(geo_dl[GEO_DLY-1].x12)), .b(d1x2_s7), .p(m4));

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s13   <= U_W'(m1) + U_W'(m2);
			uy_s13   <= U_W'(m3) + U_W'(m4);
			uxa_s14  <= ux_s13[U_W-1] ? U_W'(-ux_s13) : U_W'(ux_s13);
			uya_s14  <= uy_s13[U_W-1] ? U_W'(-uy_s13) : U_W'(uy_s13);
			ad_s14   <= d2_dl[D2_DLY-1][DET_W-1] ? DET_W'(-d2_dl[D2_DLY-1]) :
				DET_W'(d2_dl[D2_DLY-1]);
			numx_s15 <= NUM_W'(uxa_s14) + NUM_W'(ad_s14);
			numy_s15 <= NUM_W'(uya_s14) + NUM_W'(ad_s14);
			den_s15  <= {ad_s14, 1'b0};
		end
	end

	ccirc_div #(.NW(NUM_W), .DW(DEN_W), .QW(Q_W)) u_div_x (
		.clk(clk), .en(en), .n(numx_s15), .d(den_s15), .q(qx), .ovf(ovfx));
	ccirc_div #(.NW(NUM_W), .DW(DEN_W), .QW(Q_W)) u_div_y (
		.clk(clk), .en(en), .n(numy_s15), .d(den_s15), .q(qy), .ovf(ovfy));

	always_ff @(posedge clk) begin
		if (en) begin
			sat_dl[0] <= ovfx || ovfy;
			for (int k = 1; k < SAT_DLY; k++) begin
				sat_dl[k] <= sat_dl[k-1];
			end
		end
	end

	ccirc_mul #(.AW(SQI_W), .BW(SQI_W)) u_mul_sqx (
		.clk(clk), .en(en), .a({1'b0, qx}), .b({1'b0, qx}), .p(sqx));
	ccirc_mul #(.AW(SQI_W), .BW(SQI_W)) u_mul_sqy (
		.clk(clk), .en(en), .a({1'b0, qy}), .b({1'b0, qy}), .p(sqy));

	always_ff @(posedge clk) begin
		if (en) begin
			t_s68 <= T_W'(sqx[T_W-2:0]) + T_W'(sqy[T_W-2:0]);
		end
	end

	// Digit-by-digit square root, one result bit per stage, highest bit first.
	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		localparam int B = ROOT_W - 1 - k;
		logic [RAD_W-1:0]  rem_prev;
		logic [ROOT_W-1:0] root_prev;
		logic [TR_W-1:0]   trial;
		logic [TR_W-1:0]   dif;

		if (k == 0) begin : g_first
			assign rem_prev  = RAD_W'(t_s68) << RAD_SHIFT;
			assign root_prev = '0;
		end else begin : g_next
			assign rem_prev  = rt_rem_s[k-1];
			assign root_prev = rt_root_s[k-1];
		end

		assign trial = (TR_W'(root_prev) << (B + 1)) | (TR_W'(1) << (2 * B));
		assign dif   = TR_W'(rem_prev) - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rt_rem_s[k]  <= dif[TR_W-1] ? rem_prev : dif[RAD_W-1:0];
				rt_root_s[k] <= root_prev | (ROOT_W'(!dif[TR_W-1]) << B);
			end
		end
	end

	ccirc_mul #(.AW(TWOPI_W + 1), .BW(ROOT_W + 1)) u_mul_fin (
		.clk(clk), .en(en), .a({1'b0, TWOPI_Q48}), .b({1'b0, rt_root_s[ROOT_W-1]}),
		.p(prod));

	assign p_c    = FIN_W'(prod) + (FIN_W'(1) << (ROUND_POS - 1));
	assign sat2_c = |p_c[FIN_W-1:ROUND_POS+OUT_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			if (coll_dl[COLL_DLY-1]) begin
				res_s137.circumference  <= '0;
				res_s137.collinear_flag <= 1'b1;
				res_s137.saturated_flag <= 1'b0;
			end else if (sat_dl[SAT_DLY-1] || sat2_c) begin
				res_s137.circumference  <= '1;
				res_s137.collinear_flag <= 1'b0;
				res_s137.saturated_flag <= 1'b1;
			end else begin
				res_s137.circumference  <= p_c[ROUND_POS +: OUT_BITS];
				res_s137.collinear_flag <= 1'b0;
				res_s137.saturated_flag <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_coll_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.collinear_flag |-> res.circumference == '0 && !res.saturated_flag)
		else $error("Collinear result carries a nonzero value or saturation.");

	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.saturated_flag |-> (&res.circumference) && !res.collinear_flag)
		else $error("Saturated result is not the full-scale value.");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !pts_ready)
		else $error("Input transfer taken while the output is stalled.");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		pts_valid && pts_ready |=> vld_s[1])
		else $error("Accepted transfer did not enter the pipeline.");
`endif

endmodule
